/* rtl/core/rfs_pkg.sv */
// Shared types and constants for the repeat frame suppressor.
package rfs_pkg;

  localparam int unsigned ENTRIES_DEF = 32;

  localparam int unsigned FID_W  = 12;
  localparam int unsigned CMD_W  = 8;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned TMO_W  = 32;
  localparam int unsigned CFG_AW = 1;
  localparam int unsigned CFG_DW = 32;

  localparam logic [CFG_AW-1:0] REG_TIMEOUT    = 1'd0;
  localparam logic [CFG_AW-1:0] REG_AUTO_STORE = 1'd1;

  localparam logic [TMO_W-1:0] TIMEOUT_RST = 32'd1000000;

  localparam logic OP_CHECK   = 1'b0;
  localparam logic OP_PRELOAD = 1'b1;

  // one table entry as stored in the key/record RAM
  typedef struct packed {
    logic              id_only;
    logic [FID_W-1:0]  fid;
    logic [CMD_W-1:0]  cmd;
    logic [SUM_W-1:0]  sum;
    logic [TIME_W-1:0] stamp;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/rfs_ram.sv */
// Generic single write port RAM with registered read.
module rfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/repeat_frame_suppressor_top.sv */
// Top level of the repeat frame suppressor: entry scan sequencer and update.
//
// Input channel (in_valid/in_ready) carries one beat per frame: a check of a
// received frame (opcode 0) or a preload of a watched key (opcode 1).
// Output channel (out_valid/out_ready) returns one beat per input beat with
// repeat_res and table_full, in input order.
// An accepted beat is matched against the table by a scan that reads one
// RAM entry per cycle through a single key comparator; the scan stops at the
// first exact key hit. in_ready is low from accept until the update cycle
// has pushed the result into the output register; the next beat can be
// taken while that result still waits for out_ready.
// If the receiver stalls with a result pending, the next beat's scan runs
// but its update holds until the pending result is taken.
// Reset (rst, synchronous) empties the table by clearing the fill count,
// drops any pending result and loads the default registers: repeat_timeout
// 1000000, auto_store 0. Configuration writes take effect at once.
module repeat_frame_suppressor_top #(
  parameter int unsigned ENTRIES = rfs_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      opcode,
  input  logic [rfs_pkg::FID_W-1:0]  frame_id,
  input  logic [rfs_pkg::CMD_W-1:0]  command_byte,
  input  logic                      ignore_command,
  input  logic [rfs_pkg::SUM_W-1:0]  checksum,
  input  logic [rfs_pkg::TIME_W-1:0] now,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      repeat_res,
  output logic                      table_full,
  input  logic                      cfg_we,
  input  logic [rfs_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [rfs_pkg::CFG_DW-1:0] cfg_wdata
);

  import rfs_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    UPDATE
  } state_t;

  state_t state;

  // configuration
  logic [TMO_W-1:0] repeat_timeout;
  logic             auto_store;

  // latched item
  logic              it_op;
  logic [FID_W-1:0]  it_fid;
  logic [CMD_W-1:0]  it_cmd;
  logic              it_ign;
  logic [SUM_W-1:0]  it_sum;
  logic [TIME_W-1:0] it_now;

  logic [CW-1:0] fill_count;
  logic [CW-1:0] iss_cnt;
  logic          rd_pend;
  logic [AW-1:0] rd_idx;

  // primary hit: exact key (check) or the preload's own key kind
  logic              hit_a;
  logic [AW-1:0]     idx_a;
  logic [SUM_W-1:0]  sum_a;
  logic [TIME_W-1:0] time_a;
  // secondary hit: identifier-only key, check beats only
  logic              hit_b;
  logic [AW-1:0]     idx_b;
  logic [SUM_W-1:0]  sum_b;
  logic [TIME_W-1:0] time_b;

  entry_t        rd_ent;
  logic [ENTRY_W-1:0] rd_data;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_ent;

  assign rd_ent = entry_t'(rd_data);

  rfs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_ent),
    .raddr (iss_cnt[AW-1:0]),
    .rdata (rd_data)
  );

  // shared key comparator on the entry read last cycle
  logic fid_eq, full_hit, idonly_hit, prim_hit, sec_hit;

  always_comb begin
    fid_eq     = rd_ent.fid == it_fid;
    full_hit   = !rd_ent.id_only && fid_eq && (rd_ent.cmd == it_cmd);
    idonly_hit = rd_ent.id_only && fid_eq;
    prim_hit   = rd_pend && ((it_op == OP_PRELOAD && it_ign) ? idonly_hit : full_hit);
    sec_hit    = rd_pend && (it_op == OP_CHECK) && idonly_hit;
  end

  logic issue, scan_done, table_room, upd_go;

  assign issue      = (state == SCAN) && (iss_cnt != fill_count) && !hit_a && !prim_hit;
  assign scan_done  = !rd_pend && (hit_a || (iss_cnt == fill_count));
  assign table_room = fill_count != CW'(ENTRIES);
  assign upd_go     = (state == UPDATE) && (!out_valid || out_ready);
  assign in_ready   = (state == IDLE);

  // update decision, one wide subtract and compare
  logic              sel_hit;
  logic [AW-1:0]     sel_idx;
  logic [SUM_W-1:0]  sel_sum;
  logic [TIME_W-1:0] sel_time;
  logic [TIME_W-1:0] age;
  logic              timed_out;
  logic              upd_rep, upd_full, upd_add;

  always_comb begin
    sel_hit   = hit_a || hit_b;
    sel_idx   = hit_a ? idx_a : idx_b;
    sel_sum   = hit_a ? sum_a : sum_b;
    sel_time  = hit_a ? time_a : time_b;
    age       = it_now - sel_time;
    timed_out = age >= {{(TIME_W - TMO_W){1'b0}}, repeat_timeout};

    wr_en    = 1'b0;
    wr_addr  = fill_count[AW-1:0];
    upd_rep  = 1'b0;
    upd_full = 1'b0;
    upd_add  = 1'b0;
    wr_ent.id_only = it_ign;
    wr_ent.fid     = it_fid;
    wr_ent.cmd     = it_ign ? '0 : it_cmd;
    wr_ent.sum     = '0;
    wr_ent.stamp   = '0;

    if (it_op == OP_PRELOAD) begin
      if (hit_a) begin
        wr_en   = upd_go;
        wr_addr = idx_a;
      end else if (table_room) begin
        wr_en   = upd_go;
        upd_add = 1'b1;
      end else begin
        upd_full = 1'b1;
      end
    end else begin
      wr_ent.sum   = it_sum;
      wr_ent.stamp = it_now;
      if (sel_hit) begin
        // rewrite the matched key as it was stored
        wr_ent.id_only = !hit_a;
        wr_ent.cmd     = hit_a ? it_cmd : '0;
        wr_addr        = sel_idx;
        if (sel_sum == it_sum && !timed_out) begin
          upd_rep = 1'b1;
        end else begin
          wr_en = upd_go;
        end
      end else if (auto_store) begin
        wr_ent.id_only = 1'b0;
        wr_ent.cmd     = it_cmd;
        if (table_room) begin
          wr_en   = upd_go;
          upd_add = 1'b1;
        end else begin
          upd_full = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      fill_count     <= '0;
      iss_cnt        <= '0;
      rd_pend        <= 1'b0;
      hit_a          <= 1'b0;
      hit_b          <= 1'b0;
      out_valid      <= 1'b0;
      repeat_timeout <= TIMEOUT_RST;
      auto_store     <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_TIMEOUT:    repeat_timeout <= cfg_wdata[TMO_W-1:0];
          REG_AUTO_STORE: auto_store     <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (in_valid) begin
            it_op   <= opcode;
            it_fid  <= frame_id;
            it_cmd  <= command_byte;
            it_ign  <= ignore_command;
            it_sum  <= checksum;
            it_now  <= now;
            iss_cnt <= '0;
            rd_pend <= 1'b0;
            hit_a   <= 1'b0;
            hit_b   <= 1'b0;
            state   <= SCAN;
          end
        end
        SCAN: begin
          rd_pend <= issue;
          if (issue) begin
            iss_cnt <= iss_cnt + CW'(1);
            rd_idx  <= iss_cnt[AW-1:0];
          end
          if (prim_hit && !hit_a) begin
            hit_a  <= 1'b1;
            idx_a  <= rd_idx;
            sum_a  <= rd_ent.sum;
            time_a <= rd_ent.stamp;
          end
          if (sec_hit && !hit_b) begin
            hit_b  <= 1'b1;
            idx_b  <= rd_idx;
            sum_b  <= rd_ent.sum;
            time_b <= rd_ent.stamp;
          end
          if (scan_done) begin
            state <= UPDATE;
          end
        end
        UPDATE: begin
          if (upd_go) begin
            out_valid  <= 1'b1;
            repeat_res <= upd_rep;
            table_full <= upd_full;
            if (upd_add) begin
              fill_count <= fill_count + CW'(1);
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/rfs_checker.sv */
// Port-level assertions for the repeat frame suppressor, bound to the top.
module rfs_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic repeat_res,
  input logic table_full
);

  // one beat in flight: input closes right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  // a fresh result only ever comes out of a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a beat in work");

  // a dropped key is never a repeat
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(repeat_res && table_full))
    else $error("repeat_res and table_full both set");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(repeat_res) && $stable(table_full)))
    else $error("stalled result beat changed");

  a_reset_state: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

endmodule

bind repeat_frame_suppressor_top rfs_checker u_rfs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .repeat_res (repeat_res),
  .table_full (table_full)
);

/* tb/sv/tb_repeat_frame_suppressor_top.sv */
// Self-checking testbench for repeat_frame_suppressor_top: directed table, then random phases.
module tb_repeat_frame_suppressor_top;
  import rfs_pkg::*;

  localparam int unsigned ENTRIES     = ENTRIES_DEF;
  localparam int          KEYS        = 20;
  localparam int          LONG_HOLD   = 400;
  localparam int          CYCLE_LIMIT = 1000000;
  localparam bit          TYPED       = 1'b1;
  localparam bit          PRED        = 1'b0;

  typedef struct packed {
    logic              op;
    logic [FID_W-1:0]  fid;
    logic [CMD_W-1:0]  cmd;
    logic              ign;
    logic [SUM_W-1:0]  sum;
    logic [TIME_W-1:0] now;
  } frame_t;

  typedef struct packed {
    logic rep;
    logic full;
  } verdict_t;

  typedef struct packed {
    frame_t   f;
    logic     typed;
    verdict_t v;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                opcode = OP_CHECK;
  logic [FID_W-1:0]    frame_id = '0;
  logic [CMD_W-1:0]    command_byte = '0;
  logic                ignore_command = 1'b0;
  logic [SUM_W-1:0]    checksum = '0;
  logic [TIME_W-1:0]   now = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                repeat_res;
  logic                table_full;
  logic                cfg_we = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr = REG_TIMEOUT;
  logic [CFG_DW-1:0]   cfg_wdata = '0;

  // predictor state
  entry_t              watch_tbl [ENTRIES];
  int unsigned         watch_fill = 0;
  logic [TMO_W-1:0]    watch_tmo = TIMEOUT_RST;
  logic                watch_auto = 1'b0;

  verdict_t            pending_verdicts [$];
  dir_row_t            dir_rows [$];
  int                  mismatch_cnt = 0;
  int                  cycle_cnt = 0;

  // stimulus helpers
  logic [FID_W-1:0]    key_fid [KEYS];
  logic [CMD_W-1:0]    key_cmd [KEYS];
  logic                key_ido [KEYS];
  logic [TIME_W-1:0]   t_cur = '0;

  // receiver control
  bit                  rx_idle_on = 1'b1;
  int                  rx_long_req = 0;
  int                  rx_long_seen = 0;
  int                  rx_stall_left = 0;

  repeat_frame_suppressor_top u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .opcode         (opcode),
    .frame_id       (frame_id),
    .command_byte   (command_byte),
    .ignore_command (ignore_command),
    .checksum       (checksum),
    .now            (now),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .repeat_res     (repeat_res),
    .table_full     (table_full),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int find_slot(input logic id_only, input logic [FID_W-1:0] fid,
                                   input logic [CMD_W-1:0] cmd);
    for (int i = 0; i < int'(watch_fill); i++) begin
      if (watch_tbl[i].id_only == id_only && watch_tbl[i].fid == fid &&
          (id_only || watch_tbl[i].cmd == cmd))
        return i;
    end
    return -1;
  endfunction

  function automatic void store_key(input logic id_only, input logic [FID_W-1:0] fid,
                                    input logic [CMD_W-1:0] cmd, input logic [SUM_W-1:0] sum,
                                    input logic [TIME_W-1:0] stamp);
    watch_tbl[watch_fill].id_only = id_only;
    watch_tbl[watch_fill].fid     = fid;
    watch_tbl[watch_fill].cmd     = id_only ? '0 : cmd;
    watch_tbl[watch_fill].sum     = sum;
    watch_tbl[watch_fill].stamp   = stamp;
    watch_fill++;
  endfunction

  // updates the watch table for one frame and returns its verdict
  function automatic verdict_t suppress_predict(input frame_t f);
    verdict_t v;
    int       idx;
    v = '0;
    if (f.op == OP_PRELOAD) begin
      idx = find_slot(f.ign, f.fid, f.cmd);
      if (idx >= 0) begin
        watch_tbl[idx].sum   = '0;
        watch_tbl[idx].stamp = '0;
      end else if (watch_fill < ENTRIES) begin
        store_key(f.ign, f.fid, f.cmd, '0, '0);
      end else begin
        v.full = 1'b1;
      end
    end else begin
      idx = find_slot(1'b0, f.fid, f.cmd);
      if (idx < 0)
        idx = find_slot(1'b1, f.fid, f.cmd);
      if (idx >= 0) begin
        if (watch_tbl[idx].sum == f.sum) begin
          // elapsed time wraps modulo 2^64
          if (f.now - watch_tbl[idx].stamp >= TIME_W'(watch_tmo))
            watch_tbl[idx].stamp = f.now;
          else
            v.rep = 1'b1;
        end else begin
          watch_tbl[idx].sum   = f.sum;
          watch_tbl[idx].stamp = f.now;
        end
      end else if (watch_auto) begin
        if (watch_fill < ENTRIES)
          store_key(1'b0, f.fid, f.cmd, f.sum, f.now);
        else
          v.full = 1'b1;
      end
    end
    return v;
  endfunction

  // result side: check each beat, then pick out_ready for the next cycle
  always @(posedge clk) begin : rx_side
    verdict_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: repeat_res=%0b table_full=%0b",
                   repeat_res, table_full);
      end else begin
        want = pending_verdicts.pop_front();
        if (repeat_res !== want.rep || table_full !== want.full) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: repeat_res exp %0b got %0b, table_full exp %0b got %0b",
                     want.rep, repeat_res, want.full, table_full);
        end
      end
    end
    if (rx_long_req != rx_long_seen) begin
      rx_long_seen  = rx_long_req;
      rx_stall_left = LONG_HOLD;
    end
    if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_ready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall_left = $urandom_range(1, 17) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_frame(input frame_t f, input bit typed, input verdict_t tv);
    verdict_t v;
    in_valid       <= 1'b1;
    opcode         <= f.op;
    frame_id       <= f.fid;
    command_byte   <= f.cmd;
    ignore_command <= f.ign;
    checksum       <= f.sum;
    now            <= f.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = suppress_predict(f);
    pending_verdicts.push_back(typed ? tv : v);
  endtask

  task automatic idle_gap();
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 17)) @(posedge clk);
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic cfg_write(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (a == REG_TIMEOUT)
      watch_tmo = d[TMO_W-1:0];
    else
      watch_auto = d[0];
    @(posedge clk);
  endtask

  function automatic void add_vec(input logic op, input logic [FID_W-1:0] fid,
                                  input logic [CMD_W-1:0] cmd, input logic ign,
                                  input logic [SUM_W-1:0] sum, input logic [TIME_W-1:0] t,
                                  input bit typed, input logic rep, input logic full);
    dir_row_t r;
    r.f.op  = op;
    r.f.fid = fid;
    r.f.cmd = cmd;
    r.f.ign = ign;
    r.f.sum = sum;
    r.f.now = t;
    r.typed = typed;
    r.v.rep = rep;
    r.v.full = full;
    dir_rows.push_back(r);
  endfunction

  // one random phase: idle, reconfigure, then n frames mostly on the watched key pool
  task automatic run_phase(input int n, input logic [TMO_W-1:0] tmo, input logic auto_v,
                           input int noise_pct, input bit idle_on, input bit long_hold);
    frame_t   f;
    verdict_t none;
    int       k;
    int       idx;
    logic [TIME_W-1:0] step;
    none = '0;
    drain_all();
    cfg_write(REG_TIMEOUT, CFG_DW'(tmo));
    cfg_write(REG_AUTO_STORE, CFG_DW'(auto_v));
    rx_idle_on = idle_on;
    if (long_hold)
      rx_long_req++;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2)
        drain_all();
      if (idle_on && !(long_hold && i < 30) && $urandom_range(0, 5) == 0)
        idle_gap();
      k     = $urandom_range(0, KEYS - 1);
      f.fid = key_fid[k];
      f.cmd = key_ido[k] ? CMD_W'($urandom) : key_cmd[k];
      f.op  = ($urandom_range(0, 99) < 12) ? OP_PRELOAD : OP_CHECK;
      f.ign = (f.op == OP_PRELOAD) ? key_ido[k] : 1'($urandom);
      if ($urandom_range(0, 99) < noise_pct) begin
        f.fid = FID_W'($urandom);
        f.cmd = CMD_W'($urandom);
        f.ign = 1'($urandom);
      end
      case ($urandom_range(0, 3))
        0:       step = '0;
        1:       step = TIME_W'($urandom_range(0, 64));
        2:       step = TIME_W'($urandom_range(0, 2000));
        default: step = TIME_W'($urandom);
      endcase
      t_cur = t_cur + step;
      f.now = t_cur;
      f.sum = SUM_W'($urandom);
      idx = find_slot(1'b0, f.fid, f.cmd);
      if (idx < 0)
        idx = find_slot(1'b1, f.fid, f.cmd);
      if (idx >= 0) begin
        // land just around the timeout boundary of the matching entry
        if ($urandom_range(0, 2) == 0)
          f.now = watch_tbl[idx].stamp + TIME_W'(tmo) + TIME_W'($urandom_range(0, 2)) - 1;
        if ($urandom_range(0, 9) < 6)
          f.sum = watch_tbl[idx].sum;
      end
      if ($urandom_range(0, 49) == 0)
        f.now = {$urandom, $urandom};
      send_frame(f, PRED, none);
    end
  endtask

  initial begin
    for (int k = 0; k < KEYS; k++) begin
      key_fid[k] = FID_W'($urandom);
      key_cmd[k] = CMD_W'($urandom);
      key_ido[k] = (k % 3 == 2);
      // some identifier-only keys shadow a full key's identifier
      if (k % 6 == 2)
        key_fid[k] = key_fid[k - 1];
    end

    //      op          fid      cmd    ign   sum        now                     kind   rep   full
    add_vec(OP_CHECK,   12'h000, 8'h00, 1'b0, 16'h0000, 64'd0,                  TYPED, 1'b0, 1'b0);
    add_vec(OP_CHECK,   12'hFFF, 8'hFF, 1'b1, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, 1'b0, 1'b0);
    add_vec(OP_PRELOAD, 12'h123, 8'h45, 1'b0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, TYPED, 1'b0, 1'b0);
    add_vec(OP_PRELOAD, 12'hABC, 8'h77, 1'b1, 16'h0000, 64'd0,                  TYPED, 1'b0, 1'b0);
    add_vec(OP_CHECK,   12'h123, 8'h45, 1'b0, 16'h0000, 64'd5,                  PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'h123, 8'h45, 1'b0, 16'h0000, 64'd1000000,            PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'h123, 8'h45, 1'b0, 16'h0000, 64'd1999999,            PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'h123, 8'h45, 1'b0, 16'h5555, 64'd2000000,            PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'h123, 8'h45, 1'b1, 16'h5555, 64'd2000010,            PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'h123, 8'h44, 1'b0, 16'h0000, 64'd2000020,            PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'hABC, 8'h00, 1'b1, 16'h0000, 64'd7,                  PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'hABC, 8'hFF, 1'b0, 16'h0000, 64'hFFFF_FFFF_FFFF_FFF0, PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'hABC, 8'h12, 1'b0, 16'h0000, 64'd5,                  PRED,  1'b0, 1'b0);
    add_vec(OP_PRELOAD, 12'h123, 8'h45, 1'b0, 16'h0000, 64'd0,                  TYPED, 1'b0, 1'b0);
    add_vec(OP_CHECK,   12'h123, 8'h45, 1'b0, 16'h0000, 64'd3,                  PRED,  1'b0, 1'b0);
    add_vec(OP_PRELOAD, 12'hABC, 8'h12, 1'b0, 16'h0000, 64'd0,                  TYPED, 1'b0, 1'b0);
    add_vec(OP_CHECK,   12'hABC, 8'h12, 1'b0, 16'h1234, 64'd200,                PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'hABC, 8'h13, 1'b0, 16'h0000, 64'd210,                PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'hABC, 8'h12, 1'b0, 16'h1234, 64'd220,                PRED,  1'b0, 1'b0);
    add_vec(OP_PRELOAD, 12'hABC, 8'h99, 1'b1, 16'h0000, 64'd0,                  TYPED, 1'b0, 1'b0);
    add_vec(OP_PRELOAD, 12'h000, 8'h00, 1'b0, 16'h0000, 64'd0,                  TYPED, 1'b0, 1'b0);
    add_vec(OP_PRELOAD, 12'hFFF, 8'hFF, 1'b1, 16'hFFFF, 64'd0,                  TYPED, 1'b0, 1'b0);
    add_vec(OP_CHECK,   12'hFFF, 8'h00, 1'b0, 16'h0000, 64'd0,                  PRED,  1'b0, 1'b0);
    add_vec(OP_CHECK,   12'h000, 8'h00, 1'b0, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, PRED,  1'b0, 1'b0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if ($urandom_range(0, 3) == 0)
        idle_gap();
      send_frame(dir_rows[i].f, dir_rows[i].typed, dir_rows[i].v);
    end

    run_phase(200, 32'd1000,        1'b0, 0, 1'b1, 1'b0);
    run_phase(200, 32'd0,           1'b1, 3, 1'b0, 1'b0);
    run_phase(200, 32'hFFFF_FFFF,   1'b1, 3, 1'b1, 1'b0);
    run_phase(200, 32'd1,           1'b0, 5, 1'b1, 1'b1);
    run_phase(200, TMO_W'($urandom_range(2, 70000)), 1'b1, 8, 1'b1, 1'b0);
    run_phase(200, 32'd1000000,     1'b1, 5, 1'b0, 1'b0);

    drain_all();
    repeat (60) @(posedge clk);
    if (mismatch_cnt == 0 && pending_verdicts.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/rfs_pkg.sv
rtl/core/rfs_ram.sv
rtl/core/repeat_frame_suppressor_top.sv
rtl/core/rfs_checker.sv
tb/sv/tb_repeat_frame_suppressor_top.sv
